/* sv/sorted_priority_queue_defines.svh */
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared property wrappers for the queue's checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/spq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared widths, types and codes for the queue and its cell row.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 16;

    typedef logic signed [DATA_W-1:0] t_data;

    // Operation codes carried in the mode field
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Row-wide shift commands broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

/* sv/spq_if.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface spq_in_if import spq_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  mode;
    t_data value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface spq_out_if import spq_pkg::*; #(
    parameter int CNT_W = $clog2(DEPTH_DEF + 1)
) ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    t_data            front_value;
    logic             front_valid;
    logic [CNT_W-1:0] count;

    modport source (output valid, output status, output front_value,
                    output front_valid, output count, input ready);
    modport sink   (input valid, input status, input front_value,
                    input front_valid, input count, output ready);
endinterface

/* sv/spq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; keeps it, takes the new value, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_data     i_value,
    input  logic      i_occ,
    input  logic      i_prev_keep,
    input  t_data     i_prev_entry,
    input  t_data     i_next_entry,
    output logic      o_keep,
    output t_data     o_entry,
    output t_data     o_next
);

    t_data r_entry;
    t_data n_entry;

    // Stored entry stays ahead of the new value when it is >= (FIFO on ties)
    assign o_keep = i_occ && (r_entry >= i_value);

    // Insert: keep, take value at the boundary, else shift down; remove: shift up
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_prev_keep) begin
                n_entry = i_value;
            end else begin
                n_entry = i_prev_entry;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

/* sv/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue
// Descending-order queue of signed words built from a row of shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  carries operation beats: mode selects insert (value) or remove-front.
//   o_out carries one result beat per operation: status, new front, count.
//   An operation beat is taken whenever the result register is empty or its
//   beat is being taken in the same cycle, so the queue sustains one
//   operation per cycle; the result appears in the cycle after acceptance.
//   All cells compare against the incoming value in parallel and shift
//   together; the result is held in a single result register.
//   When the receiver stalls, the result holds and i_in.ready drops until it
//   is taken. Ties are inserted behind equal entries. A full insert reports
//   ST_FULL and an empty remove ST_EMPTY, both leaving the queue unchanged.
//   Reset empties the queue (count zero) and clears the result valid flag;
//   no clearing pass is needed, the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_status          r_status;
    t_status          n_status;
    t_data            r_front;
    logic             r_front_valid;
    logic [CNT_W-1:0] r_out_count;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    t_cell_ctl        w_ctl;

    logic             w_keep  [DEPTH];
    t_data            w_entry [DEPTH];
    t_data            w_next  [DEPTH];

    // Accept when the result register is free or draining this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // Row commands and status decode
    always_comb begin
        w_ctl    = '0;
        n_status = ST_OK;
        if (i_in.mode == MODE_INSERT) begin
            w_ctl.ins = w_accept && !w_full;
            n_status  = w_full ? ST_FULL : ST_OK;
        end else begin
            w_ctl.rem = w_accept && !w_empty;
            n_status  = w_empty ? ST_EMPTY : ST_OK;
        end
    end

    // Occupancy update
    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Cell row: each cell sees its neighbors' entries and the left keep flag
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic  w_prev_keep;
        t_data w_prev_entry;
        t_data w_next_entry;

        if (gi == 0) begin : g_head
            assign w_prev_keep  = 1'b1;
            assign w_prev_entry = i_in.value;
        end else begin : g_body
            assign w_prev_keep  = w_keep[gi-1];
            assign w_prev_entry = w_entry[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_next_entry = w_entry[gi];
        end else begin : g_inner
            assign w_next_entry = w_entry[gi+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_value      (i_in.value),
            .i_occ        (CNT_W'(gi) < r_count),
            .i_prev_keep  (w_prev_keep),
            .i_prev_entry (w_prev_entry),
            .i_next_entry (w_next_entry),
            .o_keep       (w_keep[gi]),
            .o_entry      (w_entry[gi]),
            .o_next       (w_next[gi])
        );
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, captured with the post-step front
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= n_status;
            r_front       <= (n_count != '0) ? w_next[0] : '0;
            r_front_valid <= (n_count != '0);
            r_out_count   <= n_count;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.front_value = r_front;
    assign o_out.front_valid = r_front_valid;
    assign o_out.count       = r_out_count;

endmodule

/* sv/spq_checker.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level consistency checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_defines.svh"

module spq_checker import spq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [1:0]       i_status,
    input t_data            i_front_value,
    input logic             i_front_valid,
    input logic [CNT_W-1:0] i_count
);

    // Front flag tracks a non-empty queue
    `SPQ_ASSERT_NOW(a_front_valid, i_clk, i_rst_n, i_out_valid, i_front_valid == (i_count != '0), "front_valid disagrees with count")

    // Empty queue shows a zero front
    `SPQ_ASSERT_NOW(a_front_zero, i_clk, i_rst_n, i_out_valid && !i_front_valid, i_front_value == '0, "empty queue with nonzero front")

    // Full rejection only when the queue is full
    `SPQ_ASSERT_NOW(a_full_cnt, i_clk, i_rst_n, i_out_valid && (i_status == ST_FULL), i_count == CNT_W'(DEPTH), "full status below depth")

    // Empty rejection only when the queue is empty
    `SPQ_ASSERT_NOW(a_empty_cnt, i_clk, i_rst_n, i_out_valid && (i_status == ST_EMPTY), i_count == '0, "empty status with entries")

    // A stalled result beat stays offered
    `SPQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result beat dropped while stalled")

endmodule

bind sorted_priority_queue spq_checker #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
) u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_front_value (o_out.front_value),
    .i_front_valid (o_out.front_valid),
    .i_count       (o_out.count)
);
